// ===== rtl/core/scag_pkg.sv =====
`timescale 1ns / 1ps

package scag_pkg;

  // fixed widths of the register file and of the address ports
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int RANK_W     = 3;
  localparam int OUT_ADDR_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK        = 3'd0,
    CFG_EXTENTS     = 3'd1,
    CFG_SRC_STRIDES = 3'd2,
    CFG_DST_STRIDES = 3'd3,
    CFG_SRC_BASE    = 3'd4,
    CFG_DST_BASE    = 3'd5
  } cfg_reg_e;

  // outcome of one advance request at the walker
  typedef struct packed {
    logic emit;
    logic last;
  } step_t;

endpackage

// ===== rtl/core/scag_walker.sv =====
`timescale 1ns / 1ps

module scag_walker #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     advance_i,
  input  logic                                     restart_i,
  input  logic [scag_pkg::RANK_W-1:0]              rank_i,
  input  logic [scag_pkg::CFG_DATA_W-1:0]          extents_i,
  output logic [EXTENT_BITS-1:0]                   idx_o [MAX_RANK],
  output scag_pkg::step_t                          step_o
);

  import scag_pkg::*;

  logic [EXTENT_BITS-1:0] idx_q   [MAX_RANK];
  logic [EXTENT_BITS-1:0] idx_d   [MAX_RANK];
  logic [EXTENT_BITS-1:0] idx_eff [MAX_RANK];
  logic [EXTENT_BITS-1:0] ext     [MAX_RANK];
  logic [MAX_RANK-1:0]    active;
  logic [MAX_RANK-1:0]    wrap;
  logic [MAX_RANK-1:0]    zero_ext;
  logic [MAX_RANK:0]      carry;
  logic                   done_q;
  logic                   done_d;
  logic                   done_eff;

  assign done_eff       = restart_i ? 1'b0 : done_q;
  assign carry[MAX_RANK] = 1'b1;

  for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
    localparam int Shift = (MAX_RANK - 1 - d) * EXTENT_BITS;
    logic [CFG_DATA_W-1:0] shifted;

    // fields at or above the top of the register read as zero
    assign shifted     = (Shift >= CFG_DATA_W) ? '0 : (extents_i >> Shift);
    assign ext[d]      = shifted[EXTENT_BITS-1:0];
    assign active[d]   = int'(rank_i) > d;
    assign idx_eff[d]  = restart_i ? '0 : idx_q[d];
    assign wrap[d]     = ({1'b0, idx_eff[d]} + (EXTENT_BITS+1)'(1)) >= {1'b0, ext[d]};
    assign zero_ext[d] = active[d] && (ext[d] == '0);
    // inactive dims pass the carry through
    assign carry[d]    = carry[d+1] && (!active[d] || wrap[d]);
    assign idx_o[d]    = active[d] ? idx_eff[d] : '0;

    always_comb begin
      idx_d[d] = idx_eff[d];
      if (step_o.emit && !step_o.last && active[d] && carry[d+1]) begin
        idx_d[d] = wrap[d] ? '0 : (idx_eff[d] + EXTENT_BITS'(1));
      end
    end
  end

  assign step_o.emit = !done_eff && !(|zero_ext);
  assign step_o.last = carry[0];
  assign done_d      = !step_o.emit || step_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;
      for (int d = 0; d < MAX_RANK; d++) begin
        idx_q[d] <= '0;
      end
    end else if (advance_i) begin
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && step_o.emit && step_o.last |=> done_q)
    else $error("walk not closed after final pair");

  a_more_keeps_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && step_o.emit && !step_o.last |=> !done_q)
    else $error("walk closed before final pair");

  a_idle_holds_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(idx_q[MAX_RANK-1]) && $stable(done_q))
    else $error("walker state moved without a request");
`endif

endmodule

// ===== rtl/core/strided_copy_address_generator.sv =====
`timescale 1ns / 1ps

// N-dimensional strided copy address generator. Each accepted advance request
// yields the next source/destination element address pair of a row-major walk
// (dimension 0 outermost, last active dimension fastest), each address being
// base plus the sum of index times signed stride, wrapped to the address
// width; last marks the final pair. Restart zeroes the indices and opens a new
// walk; without a restart after the final pair, requests produce nothing, and
// a zero extent in any active dimension closes the walk with no pair at all.
// Rank zero gives one pair at the bases. Throughput is one request per cycle
// unless a stalled output has filled the pipe: the index counter updates in
// the cycle of acceptance, so the odometer carry across the dimensions is the
// per-request loop. Each pair passes the index snapshot at the accepting edge,
// then the product stage and the sum stage, and a stalled output holds the
// pipe while earlier stages keep filling. Registers are written through
// the config port with cfg_ready_o always high; write them only while no pair
// is in flight. No clearing pass is needed after reset.
module strided_copy_address_generator #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [scag_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [scag_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // advance requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  // address pairs
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [scag_pkg::OUT_ADDR_W-1:0]     src_addr_o,
  output logic [scag_pkg::OUT_ADDR_W-1:0]     dst_addr_o,
  output logic                                last_o
);

  import scag_pkg::*;

  // effective address width: the narrower of the parameter and the port
  localparam int AW = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
  // signed product of a zero-extended index and a signed stride
  localparam int PW = 2 * EXTENT_BITS + 1;
  localparam int XW = (PW > AW) ? PW : AW;

  // config registers
  logic [RANK_W-1:0]     rank_q;
  logic [CFG_DATA_W-1:0] extents_q;
  logic [CFG_DATA_W-1:0] src_strides_q;
  logic [CFG_DATA_W-1:0] dst_strides_q;
  logic [OUT_ADDR_W-1:0] src_base_q;
  logic [OUT_ADDR_W-1:0] dst_base_q;

  // walker front end
  logic                   in_accept;
  logic [EXTENT_BITS-1:0] walk_idx [MAX_RANK];
  step_t                  walk_step;

  // pipeline stages
  logic                   s1_valid_q;
  logic                   s1_last_q;
  logic [EXTENT_BITS-1:0] s1_idx_q [MAX_RANK];
  logic                   s2_valid_q;
  logic                   s2_last_q;
  logic [AW-1:0]          s2_src_prod_q [MAX_RANK];
  logic [AW-1:0]          s2_dst_prod_q [MAX_RANK];
  logic [AW-1:0]          s2_src_prod_d [MAX_RANK];
  logic [AW-1:0]          s2_dst_prod_d [MAX_RANK];
  logic                   out_valid_q;
  logic                   out_last_q;
  logic [AW-1:0]          out_src_q;
  logic [AW-1:0]          out_dst_q;
  logic [AW-1:0]          src_sum;
  logic [AW-1:0]          dst_sum;

  logic out_free;
  logic s2_free;
  logic s1_free;

  // ---------------------------------------------------------------------------
  // config port: always ready, writes beyond the register list are dropped
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q        <= '0;
      extents_q     <= '0;
      src_strides_q <= '0;
      dst_strides_q <= '0;
      src_base_q    <= '0;
      dst_base_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RANK:        rank_q        <= cfg_data_i[RANK_W-1:0];
        CFG_EXTENTS:     extents_q     <= cfg_data_i;
        CFG_SRC_STRIDES: src_strides_q <= cfg_data_i;
        CFG_DST_STRIDES: dst_strides_q <= cfg_data_i;
        CFG_SRC_BASE:    src_base_q    <= cfg_data_i[OUT_ADDR_W-1:0];
        CFG_DST_BASE:    dst_base_q    <= cfg_data_i[OUT_ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: each stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // index counter and walk status; requests with no pair never enter the pipe
  scag_walker #(
    .MAX_RANK    (MAX_RANK),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .restart_i (restart_i),
    .rank_i    (rank_q),
    .extents_i (extents_q),
    .idx_o     (walk_idx),
    .step_o    (walk_step)
  );

  // ---------------------------------------------------------------------------
  // stride products, one multiplier per dimension and side
  // ---------------------------------------------------------------------------
  for (genvar d = 0; d < MAX_RANK; d++) begin : g_prod
    localparam int Shift = (MAX_RANK - 1 - d) * EXTENT_BITS;
    logic [CFG_DATA_W-1:0]         src_shifted;
    logic [CFG_DATA_W-1:0]         dst_shifted;
    logic signed [EXTENT_BITS-1:0] src_stride;
    logic signed [EXTENT_BITS-1:0] dst_stride;
    logic signed [PW-1:0]          src_prod;
    logic signed [PW-1:0]          dst_prod;
    logic signed [XW-1:0]          src_ext;
    logic signed [XW-1:0]          dst_ext;

    // strides outside the register read as zero
    assign src_shifted = (Shift >= CFG_DATA_W) ? '0 : (src_strides_q >> Shift);
    assign dst_shifted = (Shift >= CFG_DATA_W) ? '0 : (dst_strides_q >> Shift);
    assign src_stride  = $signed(src_shifted[EXTENT_BITS-1:0]);
    assign dst_stride  = $signed(dst_shifted[EXTENT_BITS-1:0]);
    assign src_prod    = $signed({1'b0, s1_idx_q[d]}) * src_stride;
    assign dst_prod    = $signed({1'b0, s1_idx_q[d]}) * dst_stride;
    // sign-extend, then wrap to the address width
    assign src_ext     = XW'(src_prod);
    assign dst_ext     = XW'(dst_prod);
    assign s2_src_prod_d[d] = src_ext[AW-1:0];
    assign s2_dst_prod_d[d] = dst_ext[AW-1:0];
  end

  // base plus the products of all dimensions (inactive ones carry index zero)
  always_comb begin
    src_sum = src_base_q[AW-1:0];
    dst_sum = dst_base_q[AW-1:0];
    for (int d = 0; d < MAX_RANK; d++) begin
      src_sum = src_sum + s2_src_prod_q[d];
      dst_sum = dst_sum + s2_dst_prod_q[d];
    end
  end

  // ---------------------------------------------------------------------------
  // stage valids
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_accept && walk_step.emit;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_idx_q  <= walk_idx;
      s1_last_q <= walk_step.last;
    end
    if (s2_free) begin
      s2_src_prod_q <= s2_src_prod_d;
      s2_dst_prod_q <= s2_dst_prod_d;
      s2_last_q     <= s1_last_q;
    end
    if (out_free) begin
      out_src_q  <= src_sum;
      out_dst_q  <= dst_sum;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign src_addr_o  = OUT_ADDR_W'(out_src_q);
  assign dst_addr_o  = OUT_ADDR_W'(out_dst_q);
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  // the front only stalls when every stage holds a pair
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && out_valid_q)
    else $error("request stalled with a free stage");

  // a pair reaches the output only from the product stage
  a_out_from_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q))
    else $error("output valid without a pair behind it");

  // a blocked output keeps the pair behind it
  a_s2_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && out_valid_q && !out_ready_i |=> s2_valid_q && $stable(s2_last_q))
    else $error("pair lost behind a stalled output");
`endif

endmodule

// ===== tb/tb_strided_copy_address_generator.sv =====
`timescale 1ns / 1ps

module tb_strided_copy_address_generator;
  import scag_pkg::*;

  // register indexes that the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;    // pipe is three deep, give it some slack
  localparam int HOLD_CYCLES    = 80;
  localparam int SEGMENTS       = 24;
  localparam int SEG_ADVANCES   = 60;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] src;
    logic [OUT_ADDR_W-1:0] dst;
    logic                  last;
  } addr_pair_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // predicted
    CHK_NONE,   // no pair may come out
    CHK_PAIR    // pair typed into the row
  } chk_e;

  typedef enum logic {
    ROW_CFG,
    ROW_STEP
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    chk_e                  chk;
    logic [OUT_ADDR_W-1:0] exp_src;
    logic [OUT_ADDR_W-1:0] exp_dst;
    logic                  exp_last;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  restart_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_ADDR_W-1:0] src_addr_o;
  logic [OUT_ADDR_W-1:0] dst_addr_o;
  logic                  last_o;

  // predictor copy of the registers and of the walk
  logic [RANK_W-1:0]     walk_rank;
  logic [63:0]           walk_extents;
  logic [63:0]           walk_src_stride;
  logic [63:0]           walk_dst_stride;
  logic [OUT_ADDR_W-1:0] walk_src_base;
  logic [OUT_ADDR_W-1:0] walk_dst_base;
  logic [15:0]           walk_idx [4];
  logic                  walk_done;

  addr_pair_t pending_pairs [$];
  dir_row_t   dir_rows [$];

  int mismatch_count = 0;
  int advances_done  = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  int stall_cycles   = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  strided_copy_address_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .src_addr_o  (src_addr_o),
    .dst_addr_o  (dst_addr_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // next pair of the row-major walk; returns 0 when the request yields nothing
  function automatic bit advance_walk(input logic rs, output addr_pair_t pair);
    int                    n;
    int                    d;
    logic [15:0]           ext;
    logic [15:0]           s_st;
    logic [15:0]           d_st;
    logic [OUT_ADDR_W-1:0] sa;
    logic [OUT_ADDR_W-1:0] da;
    logic                  fin;
    pair = '0;
    n = (walk_rank > 3'd4) ? 4 : int'(walk_rank);
    if (rs) begin
      for (d = 0; d < 4; d++) walk_idx[d] = '0;
      walk_done = 1'b0;
    end
    if (walk_done) return 1'b0;
    // any empty active dimension closes the walk without a pair
    for (d = 0; d < n; d++) begin
      if (walk_extents[(3-d)*16 +: 16] == 16'd0) begin
        walk_done = 1'b1;
        return 1'b0;
      end
    end
    sa  = walk_src_base;
    da  = walk_dst_base;
    fin = 1'b1;
    for (d = 0; d < n; d++) begin
      ext  = walk_extents[(3-d)*16 +: 16];
      s_st = walk_src_stride[(3-d)*16 +: 16];
      d_st = walk_dst_stride[(3-d)*16 +: 16];
      // modular product equals the signed one in the low bits
      sa = sa + {32'd0, walk_idx[d]} * {{32{s_st[15]}}, s_st};
      da = da + {32'd0, walk_idx[d]} * {{32{d_st[15]}}, d_st};
      if ({1'b0, walk_idx[d]} + 17'd1 < {1'b0, ext}) fin = 1'b0;
    end
    pair.src  = sa;
    pair.dst  = da;
    pair.last = fin;
    if (fin) begin
      walk_done = 1'b1;
    end else begin
      // odometer carry, fastest dimension last; an index past its extent wraps
      d = n;
      while (d > 0) begin
        d--;
        ext = walk_extents[(3-d)*16 +: 16];
        if ({1'b0, walk_idx[d]} + 17'd1 < {1'b0, ext}) begin
          walk_idx[d] = walk_idx[d] + 16'd1;
          break;
        end
        walk_idx[d] = '0;
      end
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_RANK:        walk_rank       = data[RANK_W-1:0];
      CFG_EXTENTS:     walk_extents    = data;
      CFG_SRC_STRIDES: walk_src_stride = data;
      CFG_DST_STRIDES: walk_dst_stride = data;
      CFG_SRC_BASE:    walk_src_base   = data[OUT_ADDR_W-1:0];
      CFG_DST_BASE:    walk_dst_base   = data[OUT_ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // one advance request; valid stays high on return so the next one can follow
  task automatic issue_advance(input logic rs, input chk_e chk,
                               input logic [OUT_ADDR_W-1:0] e_src,
                               input logic [OUT_ADDR_W-1:0] e_dst, input logic e_last);
    addr_pair_t pair;
    bit         emit;
    bit         ignored;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ignored = walk_done && !rs;
    emit    = advance_walk(rs, pair);
    if (!ignored) advances_done++;
    case (chk)
      CHK_MODEL: if (emit) pending_pairs.push_back(pair);
      CHK_PAIR:  pending_pairs.push_back({e_src, e_dst, e_last});
      default: ;
    endcase
  endtask

  // stop offering, let every pair out, then let the pipe settle
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, restart: 1'b0, chk: CHK_NONE,
            exp_src: '0, exp_dst: '0, exp_last: 1'b0};
    dir_rows.push_back(row);
  endtask

  task automatic add_step(input logic rs, input chk_e chk, input logic [OUT_ADDR_W-1:0] e_src,
                          input logic [OUT_ADDR_W-1:0] e_dst, input logic e_last);
    dir_row_t row;
    row = '{kind: ROW_STEP, idx: '0, data: '0, restart: rs, chk: chk,
            exp_src: e_src, exp_dst: e_dst, exp_last: e_last};
    dir_rows.push_back(row);
  endtask

  // receiver: random stalls, plus a long hold-off whenever the token moves
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted pair against the oldest expectation
  always @(posedge clk_i) begin : check_pairs
    addr_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected pair: expected none, actual src %h dst %h last %b",
                 $time, src_addr_o, dst_addr_o, last_o);
      end else begin
        want = pending_pairs.pop_front();
        if (src_addr_o !== want.src) begin
          mismatch_count++;
          $display("%0t src_addr mismatch: expected %h, actual %h", $time, want.src, src_addr_o);
        end
        if (dst_addr_o !== want.dst) begin
          mismatch_count++;
          $display("%0t dst_addr mismatch: expected %h, actual %h", $time, want.dst, dst_addr_o);
        end
        if (last_o !== want.last) begin
          mismatch_count++;
          $display("%0t last mismatch: expected %b, actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** strided_copy_address_generator: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int                    idle_tab [4];
    int                    stall_tab [4];
    int                    seg;
    int                    d;
    int                    target;
    int                    pick;
    bit                    in_cfg;
    bit                    hold_fired;
    logic                  rs;
    logic [RANK_W-1:0]     rnk;
    logic [15:0]           fld;
    logic [63:0]           data;
    logic [63:0]           ext_pk;
    logic [63:0]           sst_pk;
    logic [63:0]           dst_pk;
    idle_tab  = '{0, 59, 0, 14};
    stall_tab = '{0, 0, 59, 14};

    walk_rank       = '0;
    walk_extents    = '0;
    walk_src_stride = '0;
    walk_dst_stride = '0;
    walk_src_base   = '0;
    walk_dst_base   = '0;
    for (d = 0; d < 4; d++) walk_idx[d] = '0;
    walk_done = 1'b1;

    // directed rows
    // idle after reset, then the scalar walk at zero bases
    add_step(1'b0, CHK_NONE, '0, '0, 1'b0);
    add_step(1'b1, CHK_PAIR, '0, '0, 1'b1);
    add_step(1'b0, CHK_NONE, '0, '0, 1'b0);
    // bases at the extremes, upper data bits dropped
    add_cfg(CFG_SRC_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(CFG_DST_BASE, 64'hABCD_1234_5678_9ABC);
    add_step(1'b1, CHK_PAIR, 48'hFFFF_FFFF_FFFF, 48'h1234_5678_9ABC, 1'b1);
    // 2 x 3 walk, extreme strides
    add_cfg(CFG_RANK, 64'd2);
    add_cfg(CFG_EXTENTS, 64'h0002_0003_0000_0000);
    add_cfg(CFG_SRC_STRIDES, 64'h8000_7FFF_0000_0000);
    add_cfg(CFG_DST_STRIDES, 64'hFFFF_0001_0000_0000);
    add_step(1'b1, CHK_MODEL, '0, '0, 1'b0);
    repeat (5) add_step(1'b0, CHK_MODEL, '0, '0, 1'b0);
    add_step(1'b0, CHK_NONE, '0, '0, 1'b0);
    // rank above the maximum is clamped
    add_cfg(CFG_RANK, 64'd7);
    add_cfg(CFG_EXTENTS, 64'h0001_0001_0001_0002);
    add_cfg(CFG_SRC_STRIDES, 64'h0001_0002_0003_7FFF);
    add_cfg(CFG_DST_STRIDES, 64'hFFFF_8000_0001_0000);
    add_step(1'b1, CHK_MODEL, '0, '0, 1'b0);
    add_step(1'b0, CHK_MODEL, '0, '0, 1'b0);
    add_step(1'b0, CHK_NONE, '0, '0, 1'b0);
    // empty middle dimension: no pair at all
    add_cfg(CFG_RANK, 64'd3);
    add_cfg(CFG_EXTENTS, 64'h0003_0000_0002_0000);
    add_step(1'b1, CHK_NONE, '0, '0, 1'b0);
    add_step(1'b0, CHK_NONE, '0, '0, 1'b0);
    // full extents, then shrink them mid-walk so the index sits past its extent
    add_cfg(CFG_EXTENTS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_step(1'b1, CHK_MODEL, '0, '0, 1'b0);
    repeat (2) add_step(1'b0, CHK_MODEL, '0, '0, 1'b0);
    add_cfg(CFG_EXTENTS, 64'hFFFF_0001_0001_0000);
    repeat (3) add_step(1'b0, CHK_MODEL, '0, '0, 1'b0);
    // single element of rank one sits at the bases
    add_cfg(CFG_RANK, 64'd1);
    add_cfg(CFG_EXTENTS, 64'h0001_0000_0000_0000);
    add_step(1'b1, CHK_PAIR, 48'hFFFF_FFFF_FFFF, 48'h1234_5678_9ABC, 1'b1);
    // full rank, restart in the middle of the walk
    add_cfg(CFG_RANK, 64'd4);
    add_cfg(CFG_EXTENTS, 64'h0002_0002_0002_0002);
    add_step(1'b1, CHK_MODEL, '0, '0, 1'b0);
    add_step(1'b0, CHK_MODEL, '0, '0, 1'b0);
    add_step(1'b1, CHK_MODEL, '0, '0, 1'b0);
    add_step(1'b0, CHK_MODEL, '0, '0, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!in_cfg) begin
          drain_pipe();
          in_cfg = 1'b1;
        end
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (in_cfg) begin
          cfg_valid_i <= 1'b0;
          in_cfg = 1'b0;
        end
        issue_advance(dir_rows[i].restart, dir_rows[i].chk, dir_rows[i].exp_src,
                      dir_rows[i].exp_dst, dir_rows[i].exp_last);
      end
    end

    // random segments: fresh registers each time, walk state carries over
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_pipe();
      idle_pct  = idle_tab[seg % 4];
      stall_pct = stall_tab[seg % 4];

      pick = $urandom_range(99);
      if (pick < 10)      rnk = 3'd0;
      else if (pick < 15) rnk = 3'd7;
      else if (pick < 20) rnk = 3'($urandom_range(5, 6));
      else                rnk = 3'($urandom_range(1, 4));
      data = {$urandom, $urandom};
      data[RANK_W-1:0] = rnk;
      write_reg(CFG_RANK, data);

      for (d = 0; d < 4; d++) begin
        pick = $urandom_range(99);
        if (pick < 4)       fld = 16'd0;
        else if (pick < 8)  fld = 16'hFFFF;
        else if (pick < 12) fld = 16'($urandom);
        else                fld = 16'($urandom_range(1, 4));
        ext_pk[(3-d)*16 +: 16] = fld;
        pick = $urandom_range(99);
        if (pick < 5)       fld = 16'h8000;
        else if (pick < 10) fld = 16'h7FFF;
        else if (pick < 55) fld = 16'($urandom);
        else                fld = 16'($urandom_range(0, 6) - 3);
        sst_pk[(3-d)*16 +: 16] = fld;
        dst_pk[(3-d)*16 +: 16] = ($urandom_range(1)) ? 16'($urandom) :
                                                        16'($urandom_range(0, 6) - 3);
      end
      write_reg(CFG_EXTENTS, ext_pk);
      write_reg(CFG_SRC_STRIDES, sst_pk);
      write_reg(CFG_DST_STRIDES, dst_pk);

      pick = $urandom_range(99);
      write_reg(CFG_SRC_BASE, (pick < 10) ? 64'hFFFF_FFFF_FFFF_FFFF :
                              (pick < 20) ? 64'd0 : {$urandom, $urandom});
      pick = $urandom_range(99);
      write_reg(CFG_DST_BASE, (pick < 10) ? 64'hFFFF_FFFF_FFFF_FFFF :
                              (pick < 20) ? 64'd0 : {$urandom, $urandom});
      // unused indexes must not disturb anything
      if ($urandom_range(99) < 30) write_reg(CFG_SPARE_A, {$urandom, $urandom});
      if ($urandom_range(99) < 30) write_reg(CFG_SPARE_B, {$urandom, $urandom});
      cfg_valid_i <= 1'b0;

      // mostly whole walks, with the odd restart mid-walk and stray requests when done
      target     = advances_done + SEG_ADVANCES;
      hold_fired = 1'b0;
      while (advances_done < target) begin
        if (walk_done) rs = ($urandom_range(99) < 90);
        else           rs = ($urandom_range(99) < 3);
        // long receiver hold-off while requests keep coming, fills the pipe
        if (!hold_fired && (seg % 8 == 4) && advances_done >= target - 50) begin
          hold_token <= hold_token + 1;
          hold_fired = 1'b1;
        end
        issue_advance(rs, CHK_MODEL, '0, '0, 1'b0);
      end
    end

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("** strided_copy_address_generator: PASSED **");
    end else begin
      $display("** strided_copy_address_generator: FAILED **");
    end
    $finish;
  end

endmodule
